// ===== design/sps_pkg.sv =====
package sps_pkg;

    // input transaction payload
    typedef struct packed {
        logic [7:0] msg_byte;
        logic       is_last;
    } t_in;

    // output transaction payload: one group of four schedule words
    typedef struct packed {
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic [31:0] word_c;
        logic [31:0] word_d;
        logic [3:0]  group_index;
        logic        block_end;
        logic        message_end;
    } t_out;

    // controller states
    typedef enum logic [1:0] {
        ST_FILL,
        ST_PAD,
        ST_LEN,
        ST_EXPAND
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic       load_byte;
        logic       load_pad;
        logic       load_len;
        logic       step;
        logic [1:0] word_sel;
        logic [3:0] group;
        logic       final_blk;
        logic       blk_done;
        logic       msg_done;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic fill_full;
        logic pad_over;
        logic out_free;
    } t_stat;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [1:0] LAST_LANE  = 2'd3;
    localparam logic [3:0] LAST_GROUP = 4'd15;
    localparam logic [5:0] LAST_STEP  = 6'd63;
    localparam logic [5:0] LAST_FILL  = 6'd63;
    localparam logic [5:0] LEN_START  = 6'd56;

    // small sigma 0: rotr 7 ^ rotr 18 ^ shr 3
    function automatic logic [31:0] sigma0(input logic [31:0] x);
        sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    // small sigma 1: rotr 17 ^ rotr 19 ^ shr 10
    function automatic logic [31:0] sigma1(input logic [31:0] x);
        sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

// ===== design/sps_ctrl.sv =====
module sps_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_last,
    input  sps_pkg::t_stat       i_stat,
    output logic                 o_in_ready,
    output sps_pkg::t_cmd        o_cmd
);

    sps_pkg::t_state r_state, n_state;
    sps_pkg::t_state r_ret,   n_ret;
    logic            r_final, n_final;
    logic [5:0]      r_cnt,   n_cnt;
    logic            in_acc;
    logic            step;

    assign in_acc = i_in_valid && (r_state == sps_pkg::ST_FILL);

    // expansion advances unless the group would overwrite a pending result
    assign step = (r_state == sps_pkg::ST_EXPAND) &&
                  ((r_cnt[1:0] != sps_pkg::LAST_LANE) || i_stat.out_free);

    // next state
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_final = r_final;
        n_cnt   = r_cnt;
        case (r_state)
            sps_pkg::ST_FILL: begin
                if (in_acc) begin
                    if (i_stat.fill_full) begin
                        n_state = sps_pkg::ST_EXPAND;
                        n_ret   = i_in_last ? sps_pkg::ST_PAD : sps_pkg::ST_FILL;
                        n_final = 1'b0;
                    end else if (i_in_last) begin
                        n_state = sps_pkg::ST_PAD;
                    end
                end
            end
            sps_pkg::ST_PAD: begin
                if (i_stat.pad_over) begin
                    n_state = sps_pkg::ST_EXPAND;
                    n_ret   = sps_pkg::ST_LEN;
                    n_final = 1'b0;
                end else begin
                    n_state = sps_pkg::ST_LEN;
                end
            end
            sps_pkg::ST_LEN: begin
                n_state = sps_pkg::ST_EXPAND;
                n_ret   = sps_pkg::ST_FILL;
                n_final = 1'b1;
            end
            sps_pkg::ST_EXPAND: begin
                if (step) begin
                    n_cnt = r_cnt + 6'd1;
                    if (r_cnt == sps_pkg::LAST_STEP) begin
                        n_state = r_ret;
                    end
                end
            end
            default: begin
                n_state = sps_pkg::ST_FILL;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready        = (r_state == sps_pkg::ST_FILL);
        o_cmd.load_byte   = in_acc;
        o_cmd.load_pad    = (r_state == sps_pkg::ST_PAD);
        o_cmd.load_len    = (r_state == sps_pkg::ST_LEN);
        o_cmd.step        = step;
        o_cmd.word_sel    = r_cnt[1:0];
        o_cmd.group       = r_cnt[5:2];
        o_cmd.final_blk   = r_final;
        o_cmd.blk_done    = step && (r_cnt == sps_pkg::LAST_STEP);
        o_cmd.msg_done    = step && (r_cnt == sps_pkg::LAST_STEP) && r_final;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sps_pkg::ST_FILL;
            r_ret   <= sps_pkg::ST_FILL;
            r_final <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_final <= n_final;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== design/sps_dp.sv =====
module sps_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sps_pkg::t_in   i_data,
    input  sps_pkg::t_cmd  i_cmd,
    output sps_pkg::t_stat o_stat,
    output logic           o_valid,
    input  logic           i_ready,
    output sps_pkg::t_out  o_data
);

    logic [31:0]   r_w [16];
    logic [31:0]   n_w [16];
    logic [31:0]   r_col [3];
    logic [5:0]    r_fill;
    logic [60:0]   r_total;
    logic          r_valid;
    sps_pkg::t_out r_out;
    logic [31:0]   new_word;
    logic [4:0]    lane_off;

    // next schedule word from the sliding window
    assign new_word = sps_pkg::sigma1(r_w[14]) + r_w[9] + sps_pkg::sigma0(r_w[1]) + r_w[0];
    assign lane_off = {~r_fill[1:0], 3'b000};

    // window / block store update
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            n_w[i] = r_w[i];
        end
        if (i_cmd.blk_done) begin
            for (int i = 0; i < 16; i++) begin
                n_w[i] = '0;
            end
        end else if (i_cmd.step) begin
            for (int i = 0; i < 15; i++) begin
                n_w[i] = r_w[i + 1];
            end
            n_w[15] = new_word;
        end else if (i_cmd.load_byte) begin
            n_w[r_fill[5:2]][lane_off +: 8] = i_data.msg_byte;
        end else if (i_cmd.load_pad) begin
            n_w[r_fill[5:2]][lane_off +: 8] = sps_pkg::PAD_BYTE;
        end else if (i_cmd.load_len) begin
            n_w[14] = r_total[60:29];
            n_w[15] = {r_total[28:0], 3'b000};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_w[i] <= '0;
            end
        end else begin
            for (int i = 0; i < 16; i++) begin
                r_w[i] <= n_w[i];
            end
        end
    end

    // fill count and message length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_total <= '0;
        end else begin
            if (i_cmd.blk_done) begin
                r_fill <= '0;
            end else if (i_cmd.load_byte || i_cmd.load_pad) begin
                r_fill <= r_fill + 6'd1;
            end
            if (i_cmd.msg_done) begin
                r_total <= '0;
            end else if (i_cmd.load_byte) begin
                r_total <= r_total + 61'd1;
            end
        end
    end

    // word collector for the first three words of a group
    always_ff @(posedge i_clk) begin
        if (i_cmd.step && (i_cmd.word_sel != sps_pkg::LAST_LANE)) begin
            r_col[i_cmd.word_sel] <= r_w[0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.step && (i_cmd.word_sel == sps_pkg::LAST_LANE)) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && (i_cmd.word_sel == sps_pkg::LAST_LANE)) begin
            r_out.word_a      <= r_col[0];
            r_out.word_b      <= r_col[1];
            r_out.word_c      <= r_col[2];
            r_out.word_d      <= r_w[0];
            r_out.group_index <= i_cmd.group;
            r_out.block_end   <= (i_cmd.group == sps_pkg::LAST_GROUP);
            r_out.message_end <= (i_cmd.group == sps_pkg::LAST_GROUP) && i_cmd.final_blk;
        end
    end

    assign o_valid            = r_valid;
    assign o_data             = r_out;
    assign o_stat.fill_full   = (r_fill == sps_pkg::LAST_FILL);
    assign o_stat.pad_over    = (r_fill >= sps_pkg::LEN_START);
    assign o_stat.out_free    = !r_valid || i_ready;

endmodule

// ===== design/sha256_pad_and_schedule_top.sv =====
// SHA-256 padding and message schedule. Message bytes are taken one per cycle while a
// 64-byte block fills. A full block is then expanded into its 64-word schedule through a
// single sigma/adder unit over a 16-word sliding window, one word per cycle, and yields
// its words in groups of four; no bytes are taken meanwhile, and a stalled output holds the
// expansion. The byte flagged last is followed by the pad byte, then the bit length, and
// one or two final blocks.
module sha256_pad_and_schedule_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sps_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output sps_pkg::t_out o_data
);

    sps_pkg::t_cmd  cmd;
    sps_pkg::t_stat stat;

    // controller
    sps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_in_last  (i_data.is_last),
        .i_stat     (stat),
        .o_in_ready (o_ready),
        .o_cmd      (cmd)
    );

    // datapath
    sps_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (i_data),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

`ifndef NO_ASSERTIONS
    // no byte is taken in the cycle after the last byte of a message
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_data.is_last) |=> !o_ready)
        else $error("byte accepted straight after last byte");

    // a completed group never overwrites a pending result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.step && (cmd.word_sel == sps_pkg::LAST_LANE)) |-> stat.out_free)
        else $error("result overwritten");

    // message end only on the closing group of a block
    a_msg_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.message_end) |-> (o_data.block_end &&
            (o_data.group_index == sps_pkg::LAST_GROUP)))
        else $error("message end outside last group");

    // no byte is taken while a block is being expanded
    a_no_accept_expand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.step |-> !o_ready)
        else $error("byte accepted during expansion");
`endif

endmodule

// ===== dv/sha256_pad_and_schedule_top_tb.sv =====
module sha256_pad_and_schedule_top_tb;

    localparam int TOTAL_BYTES = 410;
    localparam int SHOW_LIMIT  = 10;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 80;

    // directed row: one byte, plus an optional hand-worked first group of its message
    typedef struct packed {
        logic [7:0]  msg_byte;
        logic        is_last;
        logic        typed;
        logic [31:0] typed_a;
        logic [31:0] typed_b;
    } t_row;

    localparam int N_ROWS = 17;
    localparam t_row DIRECTED [N_ROWS] = '{
        // single byte messages: byte, 0x80, zeros
        '{8'h61, 1'b1, 1'b1, 32'h61800000, 32'h00000000},
        '{8'h00, 1'b1, 1'b1, 32'h00800000, 32'h00000000},
        '{8'hFF, 1'b1, 1'b1, 32'hFF800000, 32'h00000000},
        // two bytes
        '{8'hAA, 1'b0, 1'b0, 32'h0, 32'h0},
        '{8'h55, 1'b1, 1'b1, 32'hAA558000, 32'h00000000},
        // three bytes
        '{8'h01, 1'b0, 1'b0, 32'h0, 32'h0},
        '{8'h80, 1'b0, 1'b0, 32'h0, 32'h0},
        '{8'h7F, 1'b1, 1'b1, 32'h01807F80, 32'h00000000},
        // four bytes: pad byte moves into the second word
        '{8'hDE, 1'b0, 1'b0, 32'h0, 32'h0},
        '{8'hAD, 1'b0, 1'b0, 32'h0, 32'h0},
        '{8'hBE, 1'b0, 1'b0, 32'h0, 32'h0},
        '{8'hEF, 1'b1, 1'b1, 32'hDEADBEEF, 32'h80000000},
        // five bytes, checked by the schedule model only
        '{8'h3C, 1'b0, 1'b0, 32'h0, 32'h0},
        '{8'hC3, 1'b0, 1'b0, 32'h0, 32'h0},
        '{8'h5A, 1'b0, 1'b0, 32'h0, 32'h0},
        '{8'hA5, 1'b0, 1'b0, 32'h0, 32'h0},
        '{8'h96, 1'b1, 1'b0, 32'h0, 32'h0}
    };

    // first random messages hit the padding boundaries, later ones favour them
    localparam int SIZED_LENS [4] = '{55, 56, 64, 65};
    localparam int EDGE_LENS  [9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          i_ready = 1'b0;
    sps_pkg::t_in  i_data  = '0;
    logic          o_ready;
    logic          o_valid;
    sps_pkg::t_out o_data;

    // schedule model state
    logic [31:0]   blk_words [16];
    int            blk_fill;
    logic [60:0]   msg_len_bytes;
    sps_pkg::t_out sched_q [$];

    int bytes_sent;
    int groups_seen;
    int mismatch_count;
    int hold_left;
    bit hold_done;

    sha256_pad_and_schedule_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    // clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #4800000;
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [31:0] rot_right(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] mix_lo(input logic [31:0] x);
        return rot_right(x, 7) ^ rot_right(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] mix_hi(input logic [31:0] x);
        return rot_right(x, 17) ^ rot_right(x, 19) ^ (x >> 10);
    endfunction

    function automatic void clear_block();
        for (int t = 0; t < 16; t++) blk_words[t] = '0;
        blk_fill = 0;
    endfunction

    // big-endian byte placement into the held block
    function automatic void place_byte(input int pos, input logic [7:0] b);
        blk_words[(pos >> 2) & 15] |= {24'h0, b} << ((3 - (pos & 3)) * 8);
    endfunction

    // expand the held block into 64 schedule words, queue 16 groups, clear the block
    function automatic void expand_block(input bit final_blk);
        logic [31:0]   w [64];
        sps_pkg::t_out grp;
        for (int t = 0; t < 16; t++) w[t] = blk_words[t];
        for (int t = 16; t < 64; t++)
            w[t] = mix_hi(w[t - 2]) + w[t - 7] + mix_lo(w[t - 15]) + w[t - 16];
        for (int g = 0; g < 16; g++) begin
            grp.word_a      = w[4 * g];
            grp.word_b      = w[4 * g + 1];
            grp.word_c      = w[4 * g + 2];
            grp.word_d      = w[4 * g + 3];
            grp.group_index = 4'(g);
            grp.block_end   = (g == 15);
            grp.message_end = (g == 15) && final_blk;
            sched_q.push_back(grp);
        end
        clear_block();
    endfunction

    // work out the groups that one accepted byte causes
    function automatic void predict_schedule(input sps_pkg::t_in item);
        logic [63:0] bit_len;
        place_byte(blk_fill, item.msg_byte);
        blk_fill++;
        msg_len_bytes = msg_len_bytes + 61'd1;
        if (blk_fill >= 64) expand_block(1'b0);
        if (item.is_last) begin
            place_byte(blk_fill, sps_pkg::PAD_BYTE);
            blk_fill++;
            if (blk_fill > 56) expand_block(1'b0);
            bit_len = {msg_len_bytes, 3'b000};
            blk_words[14] = bit_len[63:32];
            blk_words[15] = bit_len[31:0];
            expand_block(1'b1);
            msg_len_bytes = '0;
        end
    endfunction

    // offer one byte, wait for the transaction, then queue what it causes
    task automatic send_byte(input sps_pkg::t_in item, input bit typed,
                             input sps_pkg::t_out typed_grp);
        int first;
        if (!(bytes_sent >= 150 && bytes_sent < 260) && $urandom_range(99) < 10) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= item;
        do @(posedge i_clk); while (!o_ready);
        bytes_sent++;
        first = sched_q.size();
        predict_schedule(item);
        if (typed) sched_q[first] = typed_grp;
    endtask

    task automatic report_mismatch(input string what, input sps_pkg::t_out want,
                                   input sps_pkg::t_out got);
        mismatch_count++;
        if (mismatch_count <= SHOW_LIMIT) begin
            $display("%s: expected %h %h %h %h grp %0d blk %0b msg %0b",
                     what, want.word_a, want.word_b, want.word_c, want.word_d,
                     want.group_index, want.block_end, want.message_end);
            $display("    got %h %h %h %h grp %0d blk %0b msg %0b",
                     got.word_a, got.word_b, got.word_c, got.word_d,
                     got.group_index, got.block_end, got.message_end);
        end
    endtask

    // receiver: random stalls, one long hold-off, one stretch with no stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready   <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && groups_seen >= 120) begin
            i_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (groups_seen >= 200 && groups_seen < 300) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(99) >= 10);
        end
    end

    // compare each group taken with the oldest expected one
    always @(posedge i_clk) begin : group_check
        sps_pkg::t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            groups_seen <= groups_seen + 1;
            if (sched_q.size() == 0) begin
                report_mismatch("unexpected group", '0, o_data);
            end else begin
                want = sched_q.pop_front();
                if (o_data.word_a !== want.word_a || o_data.word_b !== want.word_b ||
                    o_data.word_c !== want.word_c || o_data.word_d !== want.word_d ||
                    o_data.group_index !== want.group_index ||
                    o_data.block_end !== want.block_end ||
                    o_data.message_end !== want.message_end)
                    report_mismatch("group mismatch", want, o_data);
            end
        end
    end

    // stimulus
    initial begin : stimulus
        sps_pkg::t_in  item;
        sps_pkg::t_out typed_grp;
        int            len;
        int            msg_no;

        clear_block();
        msg_len_bytes  = '0;
        bytes_sent     = 0;
        groups_seen    = 0;
        mismatch_count = 0;
        msg_no         = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int r = 0; r < N_ROWS; r++) begin
            item.msg_byte         = DIRECTED[r].msg_byte;
            item.is_last          = DIRECTED[r].is_last;
            typed_grp             = '0;
            typed_grp.word_a      = DIRECTED[r].typed_a;
            typed_grp.word_b      = DIRECTED[r].typed_b;
            send_byte(item, DIRECTED[r].typed, typed_grp);
        end

        // random messages, boundary lengths first
        while (bytes_sent < TOTAL_BYTES) begin
            if (msg_no < 4)
                len = SIZED_LENS[msg_no];
            else if ($urandom_range(9) < 3)
                len = EDGE_LENS[$urandom_range(8)];
            else
                len = $urandom_range(1, 40);
            if (len > TOTAL_BYTES - bytes_sent) len = TOTAL_BYTES - bytes_sent;
            for (int k = 0; k < len; k++) begin
                item.msg_byte = 8'($urandom_range(0, 255));
                item.is_last  = (k == len - 1);
                send_byte(item, 1'b0, '0);
            end
            msg_no++;
        end
        i_valid <= 1'b0;

        // drain, then allow for any stray groups
        while (sched_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && sched_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
